[design/ncdt_pkg.sv]
package ncdt_pkg;

	localparam int NODE_W    = 10;
	localparam int COORD_W   = 15;
	localparam int ENTRY_W   = 2 * COORD_W;
	localparam int DIST_W    = 16;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int IDX_EXT_W = 17;

	localparam int unsigned DIST_MAX = 46341;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_DIFF,
		ST_MULX,
		ST_MULY,
		ST_ADD,
		ST_ROOT,
		ST_DONE
	} state_t;

	// sequencer to root unit
	typedef struct packed {
		logic load;
		logic step;
	} root_ctl_t;

	// root unit to sequencer
	typedef struct packed {
		logic last;
		logic round_up;
	} root_stat_t;

endpackage

[design/ncdt_ram.sv]
module ncdt_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/ncdt_root.sv]
// Bit-serial integer square root, one result bit per step, plus the
// round-to-nearest decision from the final remainder.
module ncdt_root (
	input  logic                               clk,
	input  ncdt_pkg::root_ctl_t                ctl,
	input  logic [ncdt_pkg::SUM_W-1:0]         operand,
	output ncdt_pkg::root_stat_t               stat,
	output logic [ncdt_pkg::DIST_W-1:0]        root
);

	localparam int W = ncdt_pkg::SUM_W;

	logic [W-1:0] rem_q;
	logic [W-1:0] root_q;
	logic [W-1:0] bit_q;
	logic [W:0]   trial;
	logic         take;

	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign take  = {1'b0, rem_q} >= trial;

	// first trial bit is the top even power of two, so 16 steps end on bit 0
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q  <= operand;
			root_q <= '0;
			bit_q  <= {1'b1, {(W-1){1'b0}}};
		end else if (ctl.step) begin
			if (take) begin
				rem_q  <= W'({1'b0, rem_q} - trial);
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// remainder is s - r*r, so s > r*r + r reduces to remainder > r
	assign stat.last     = bit_q[0];
	assign stat.round_up = rem_q > root_q;
	assign root          = root_q[ncdt_pkg::DIST_W-1:0];

endmodule

[design/node_coordinate_distance_table.sv]
// Channel | Direction | Handshake           | Payload
// in      | into      | in_valid / in_stall  | operation, first_node, second_node,
//         |           |                      | coord_x, coord_y
// out     | out of    | out_valid / out_stall| distance
//
// A store transfer leaves the block idle, so it is ready again in the next cycle.
// A query holds in_stall through two RAM reads, the difference, two squares
// on one shared multiplier, the add, 16 root steps (one bit each) and a final
// state that rounds and loads the output register; no new transfer is taken meanwhile.
// The final state waits while the output register holds an untaken result.
// Reset clears the sequencer and output valid only; the coordinate RAM holds
// whatever it held and needs no clearing pass.
module node_coordinate_distance_table #(
	parameter int MAX_NODES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [ncdt_pkg::NODE_W-1:0]       first_node,
	input  logic [ncdt_pkg::NODE_W-1:0]       second_node,
	input  logic signed [ncdt_pkg::COORD_W-1:0] coord_x,
	input  logic signed [ncdt_pkg::COORD_W-1:0] coord_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ncdt_pkg::DIST_W-1:0]       distance
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int XW = ncdt_pkg::IDX_EXT_W;
	localparam int NW = ncdt_pkg::NODE_W;
	localparam int CW = ncdt_pkg::COORD_W;
	localparam int EW = ncdt_pkg::ENTRY_W;
	localparam int PW = ncdt_pkg::PROD_W;
	localparam int SW = ncdt_pkg::SUM_W;
	localparam logic [XW-1:0] NODES_EXT = XW'(MAX_NODES);

	ncdt_pkg::state_t state_q, state_d;

	logic in_xfer, out_xfer;
	logic [XW-1:0] a_ext, b_ext;
	logic a_ok, b_ok;

	// query operands
	logic [AW-1:0] a_addr_q, b_addr_q;
	logic          a_ok_q, b_ok_q;
	logic [CW-1:0] xa_q, ya_q;
	logic [CW-1:0] ax_q, ay_q;
	logic [PW-1:0] prod_q, sum_q;

	// RAM
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	logic [EW-1:0] entry_a, entry_b;

	// shared multiplier
	logic [CW-1:0]   mul_op;
	logic [2*CW-1:0] mul_res;

	// difference and magnitude
	logic [CW:0] dx, dy, abs_x, abs_y;

	// root unit
	ncdt_pkg::root_ctl_t  root_ctl;
	ncdt_pkg::root_stat_t root_stat;
	logic [SW-1:0]                 root_operand;
	logic [ncdt_pkg::DIST_W-1:0]   root_val;

	// output register
	logic                          out_valid_q;
	logic [ncdt_pkg::DIST_W-1:0]   distance_q;
	logic                          out_free, out_load;

	assign in_stall = state_q != ncdt_pkg::ST_IDLE;
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	// indices beyond the table: store dropped, query reads the origin
	assign a_ext = {(XW-NW)'(0), first_node};
	assign b_ext = {(XW-NW)'(0), second_node};
	assign a_ok  = a_ext < NODES_EXT;
	assign b_ok  = b_ext < NODES_EXT;

	assign ram_we    = in_xfer && (operation == ncdt_pkg::OP_STORE) && a_ok;
	assign ram_raddr = (state_q == ncdt_pkg::ST_RD_A) ? a_addr_q : b_addr_q;

	ncdt_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_NODES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(a_ext[AW-1:0]),
		.wdata({coord_y, coord_x}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign entry_a = a_ok_q ? ram_rdata : '0;
	assign entry_b = b_ok_q ? ram_rdata : '0;

	// entry layout: x low, y high
	assign dx    = {xa_q[CW-1], xa_q} - {entry_b[CW-1], entry_b[CW-1:0]};
	assign dy    = {ya_q[CW-1], ya_q} - {entry_b[EW-1], entry_b[EW-1:CW]};
	assign abs_x = dx[CW] ? (CW+1)'(0) - dx : dx;
	assign abs_y = dy[CW] ? (CW+1)'(0) - dy : dy;

	assign mul_op  = (state_q == ncdt_pkg::ST_MULX) ? ax_q : ay_q;
	assign mul_res = mul_op * mul_op;

	assign root_operand = {1'b0, sum_q} + {1'b0, prod_q};

	ncdt_root u_root (
		.clk    (clk),
		.ctl    (root_ctl),
		.operand(root_operand),
		.stat   (root_stat),
		.root   (root_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ncdt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		root_ctl.load = 1'b0;
		root_ctl.step = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ncdt_pkg::ST_IDLE: begin
				if (in_xfer && operation == ncdt_pkg::OP_QUERY) begin
					state_d = ncdt_pkg::ST_RD_A;
				end
			end
			ncdt_pkg::ST_RD_A: state_d = ncdt_pkg::ST_RD_B;
			ncdt_pkg::ST_RD_B: state_d = ncdt_pkg::ST_DIFF;
			ncdt_pkg::ST_DIFF: state_d = ncdt_pkg::ST_MULX;
			ncdt_pkg::ST_MULX: state_d = ncdt_pkg::ST_MULY;
			ncdt_pkg::ST_MULY: state_d = ncdt_pkg::ST_ADD;
			ncdt_pkg::ST_ADD: begin
				root_ctl.load = 1'b1;
				state_d       = ncdt_pkg::ST_ROOT;
			end
			ncdt_pkg::ST_ROOT: begin
				root_ctl.step = 1'b1;
				if (root_stat.last) begin
					state_d = ncdt_pkg::ST_DONE;
				end
			end
			ncdt_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ncdt_pkg::ST_IDLE;
				end
			end
			default: state_d = ncdt_pkg::ST_IDLE;
		endcase
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			a_addr_q <= a_ext[AW-1:0];
			b_addr_q <= b_ext[AW-1:0];
			a_ok_q   <= a_ok;
			b_ok_q   <= b_ok;
		end
		if (state_q == ncdt_pkg::ST_RD_B) begin
			xa_q <= entry_a[CW-1:0];
			ya_q <= entry_a[EW-1:CW];
		end
		if (state_q == ncdt_pkg::ST_DIFF) begin
			ax_q <= abs_x[CW-1:0];
			ay_q <= abs_y[CW-1:0];
		end
		if (state_q == ncdt_pkg::ST_MULX || state_q == ncdt_pkg::ST_MULY) begin
			prod_q <= mul_res[PW-1:0];
		end
		if (state_q == ncdt_pkg::ST_MULY) begin
			sum_q <= prod_q;
		end
		if (out_load) begin
			distance_q <= root_val + ncdt_pkg::DIST_W'(root_stat.round_up);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;

endmodule

[design/ncdt_checker.sv]
module ncdt_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                operation,
	input logic [ncdt_pkg::NODE_W-1:0]         first_node,
	input logic [ncdt_pkg::NODE_W-1:0]         second_node,
	input logic signed [ncdt_pkg::COORD_W-1:0] coord_x,
	input logic signed [ncdt_pkg::COORD_W-1:0] coord_y,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [ncdt_pkg::DIST_W-1:0]         distance
);

	// a query occupies the block
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && operation == ncdt_pkg::OP_QUERY) |=> in_stall)
		else $error("query transfer did not raise in_stall");

	// a store completes in its own cycle
	a_store_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && operation == ncdt_pkg::OP_STORE) |=> !in_stall)
		else $error("store transfer left block busy");

	// a new result only appears at the end of a query
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a query in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(distance)))
		else $error("stalled result changed");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (distance <= ncdt_pkg::DIST_W'(ncdt_pkg::DIST_MAX)))
		else $error("distance out of range");

endmodule

bind node_coordinate_distance_table ncdt_checker u_ncdt_checker (.*);
